// ----- rtl/core/sync_length_frame_deframer_defines.svh -----
// Assertion macros for the sync/length frame deframer.
// Used by the port checker; no other dependencies.
`ifndef SYNC_LENGTH_FRAME_DEFRAMER_DEFINES_SVH
`define SYNC_LENGTH_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SLFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("slfd: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define SLFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("slfd: next-cycle check failed");

`endif

// ----- rtl/core/slfd_pkg.sv -----
// Shared types and constants of the sync/length frame deframer.
// No dependencies.
package slfd_pkg;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [15:0] START_SIG_RST = 16'd16018;
	localparam logic [15:0] END_SIG_RST   = 16'd16108;
	localparam logic [15:0] MIN_FRAME_LEN = 16'd8;

	localparam logic [2:0] KIND_PAYLOAD    = 3'd0;
	localparam logic [2:0] KIND_GOOD       = 3'd1;
	localparam logic [2:0] KIND_BAD_START  = 3'd2;
	localparam logic [2:0] KIND_BAD_END    = 3'd3;
	localparam logic [2:0] KIND_BAD_LENGTH = 3'd4;

	localparam logic CFG_START_SIG = 1'b0;
	localparam logic CFG_END_SIG   = 1'b1;

	typedef enum logic [6:0] {
		PH_START_LO = 7'b0000001,
		PH_START_HI = 7'b0000010,
		PH_LEN_LO   = 7'b0000100,
		PH_LEN_HI   = 7'b0001000,
		PH_SVC_LO   = 7'b0010000,
		PH_SVC_HI   = 7'b0100000,
		PH_BODY     = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  payload;
		logic [15:0] service;
		logic [15:0] length;
		logic        done;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

// ----- rtl/core/slfd_front.sv -----
// Front end: accepts received bytes, tracks the frame phase and classifies
// each byte into zero or one result item. Depends on slfd_pkg.
module slfd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_addr,
	input  logic [15:0]          cfg_wdata,
	input  logic                 accept,
	input  logic [7:0]           rx_byte,
	output logic                 wr_en,
	output slfd_pkg::item_t      wr_item
);

	logic [15:0]      start_sig_q;
	logic [15:0]      end_sig_q;
	slfd_pkg::phase_t phase_q;
	logic [15:0]      cnt_q;
	logic [7:0]       low_q;
	logic [15:0]      len_q;
	logic [15:0]      svc_q;

	slfd_pkg::phase_t phase_d;
	logic [15:0]      cnt_d;
	logic [7:0]       low_d;
	logic [15:0]      len_d;
	logic [15:0]      svc_d;
	logic [15:0]      word;
	logic [16:0]      pos2;
	logic             restart;

	assign word = {rx_byte, low_q};
	assign pos2 = {1'b0, cnt_q} + 17'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_sig_q <= slfd_pkg::START_SIG_RST;
			end_sig_q   <= slfd_pkg::END_SIG_RST;
		end else if (cfg_we) begin
			if (cfg_addr == slfd_pkg::CFG_START_SIG) begin
				start_sig_q <= cfg_wdata;
			end else begin
				end_sig_q <= cfg_wdata;
			end
		end
	end

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q + 16'd1;
		low_d   = low_q;
		len_d   = len_q;
		svc_d   = svc_q;
		restart = 1'b0;
		wr_en   = 1'b0;
		wr_item = '0;
		unique case (phase_q)
			slfd_pkg::PH_START_LO: begin
				low_d   = rx_byte;
				phase_d = slfd_pkg::PH_START_HI;
			end
			slfd_pkg::PH_START_HI: begin
				if (word != start_sig_q) begin
					restart      = 1'b1;
					wr_en        = 1'b1;
					wr_item.kind = slfd_pkg::KIND_BAD_START;
					wr_item.done = 1'b1;
				end else begin
					phase_d = slfd_pkg::PH_LEN_LO;
				end
			end
			slfd_pkg::PH_LEN_LO: begin
				low_d   = rx_byte;
				phase_d = slfd_pkg::PH_LEN_HI;
			end
			slfd_pkg::PH_LEN_HI: begin
				if (word < slfd_pkg::MIN_FRAME_LEN) begin
					restart        = 1'b1;
					wr_en          = 1'b1;
					wr_item.kind   = slfd_pkg::KIND_BAD_LENGTH;
					wr_item.length = word;
					wr_item.done   = 1'b1;
				end else begin
					len_d   = word;
					phase_d = slfd_pkg::PH_SVC_LO;
				end
			end
			slfd_pkg::PH_SVC_LO: begin
				low_d   = rx_byte;
				phase_d = slfd_pkg::PH_SVC_HI;
			end
			slfd_pkg::PH_SVC_HI: begin
				svc_d   = word;
				phase_d = slfd_pkg::PH_BODY;
			end
			slfd_pkg::PH_BODY: begin
				if (pos2 < {1'b0, len_q}) begin
					wr_en           = 1'b1;
					wr_item.kind    = slfd_pkg::KIND_PAYLOAD;
					wr_item.payload = rx_byte;
					wr_item.service = svc_q;
					wr_item.length  = len_q;
				end else if (pos2 == {1'b0, len_q}) begin
					low_d = rx_byte;
				end else begin
					restart         = 1'b1;
					wr_en           = 1'b1;
					wr_item.kind    = (word == end_sig_q) ? slfd_pkg::KIND_GOOD
						: slfd_pkg::KIND_BAD_END;
					wr_item.service = svc_q;
					wr_item.length  = len_q;
					wr_item.done    = 1'b1;
				end
			end
			default: begin
				restart = 1'b1;
			end
		endcase
		if (restart) begin
			phase_d = slfd_pkg::PH_START_LO;
			cnt_d   = '0;
			low_d   = '0;
			len_d   = '0;
			svc_d   = '0;
		end
		if (!accept) begin
			wr_en = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= slfd_pkg::PH_START_LO;
			cnt_q   <= '0;
			low_q   <= '0;
			len_q   <= '0;
			svc_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			low_q   <= low_d;
			len_q   <= len_d;
			svc_q   <= svc_d;
		end
	end

endmodule

// ----- rtl/core/slfd_queue.sv -----
// Short result queue between the front end and the output stage.
// Depends on slfd_pkg.
module slfd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  slfd_pkg::item_t wr_item,
	input  logic            rd_en,
	output slfd_pkg::item_t rd_item,
	output slfd_pkg::qstat_t stat
);

	slfd_pkg::item_t                 mem_q [slfd_pkg::QDEPTH];
	logic [slfd_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [slfd_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [slfd_pkg::QCNT_W-1:0]     count_q;

	assign stat.full  = (count_q == slfd_pkg::QCNT_W'(slfd_pkg::QDEPTH));
	assign stat.empty = (count_q == '0);
	assign rd_item    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (!wr_en && rd_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/slfd_back.sv -----
// Back end: output register that presents the oldest result item and
// refills from the result queue. Depends on slfd_pkg.
module slfd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  slfd_pkg::qstat_t  qstat,
	input  slfd_pkg::item_t   q_item,
	output logic              q_rd,
	input  logic              pop,
	output logic              empty,
	output slfd_pkg::item_t   out_item
);

	logic            valid_q;
	slfd_pkg::item_t item_q;

	assign q_rd     = !qstat.empty && (!valid_q || pop);
	assign empty    = !valid_q;
	assign out_item = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_rd) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			item_q <= q_item;
		end
	end

endmodule

// ----- rtl/core/sync_length_frame_deframer.sv -----
// Top level of the sync/length frame deframer.
// Instantiates slfd_front, slfd_queue and slfd_back; depends on slfd_pkg.
//
// Usage:
//   Input side is a queue write port: one received byte per item, taken on
//   a clock edge with push high and full low. Result side is a queue read
//   port: while empty is low the oldest result is on the result ports, and
//   it is taken on a clock edge with pop high.
//   Each byte yields zero or one result: a payload byte, or one status item
//   (good end, bad start, bad end, bad length) that closes a frame attempt.
//   Throughput is one byte per cycle while full is low; the front end
//   classifies a byte in the cycle it is taken. A result is written to the
//   four-entry result queue at the edge that takes its byte and reaches the
//   output register, and so the ports, once that register is free. When the
//   receiver stalls, results collect in the queue and output register; full
//   rises once the queue holds four items and input stops. The user must
//   write the signature registers through cfg_we/cfg_addr/cfg_wdata only
//   while the block is idle; the block does not enforce this. Reset clears
//   the frame state, empties the result queue and the output register and
//   restores the default signatures; the block is ready the cycle after.
module sync_length_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [15:0] cfg_wdata,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  result_kind,
	output logic [7:0]  payload_byte,
	output logic [15:0] service_id,
	output logic [15:0] frame_length,
	output logic        frame_done
);

	slfd_pkg::item_t  wr_item;
	slfd_pkg::item_t  q_item;
	slfd_pkg::item_t  out_item;
	slfd_pkg::qstat_t qstat;
	logic             wr_en;
	logic             q_rd;
	logic             accept;

	assign full   = qstat.full;
	assign accept = push && !qstat.full;

	slfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.rx_byte   (rx_byte),
		.wr_en     (wr_en),
		.wr_item   (wr_item)
	);

	slfd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_item (wr_item),
		.rd_en   (q_rd),
		.rd_item (q_item),
		.stat    (qstat)
	);

	slfd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qstat    (qstat),
		.q_item   (q_item),
		.q_rd     (q_rd),
		.pop      (pop),
		.empty    (empty),
		.out_item (out_item)
	);

	assign result_kind  = out_item.kind;
	assign payload_byte = out_item.payload;
	assign service_id   = out_item.service;
	assign frame_length = out_item.length;
	assign frame_done   = out_item.done;

endmodule

// ----- rtl/core/slfd_checker.sv -----
// Port-level checker for the sync/length frame deframer, bound to the top.
// Depends on slfd_pkg and sync_length_frame_deframer_defines.svh.
`include "sync_length_frame_deframer_defines.svh"

module slfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [2:0]  result_kind,
	input logic [7:0]  payload_byte,
	input logic [15:0] service_id,
	input logic [15:0] frame_length,
	input logic        frame_done
);

	`SLFD_ASSERT_NOW(a_payload_open, clk, arst_n, !empty && (result_kind == slfd_pkg::KIND_PAYLOAD), !frame_done)
	`SLFD_ASSERT_NOW(a_status_nodata, clk, arst_n, !empty && frame_done, payload_byte == 8'd0)
	`SLFD_ASSERT_NOW(a_bad_start_clear, clk, arst_n, !empty && (result_kind == slfd_pkg::KIND_BAD_START), (service_id == 16'd0) && (frame_length == 16'd0))
	`SLFD_ASSERT_NEXT(a_stall_hold, clk, arst_n, !empty && !pop, !empty && $stable(result_kind) && $stable(frame_length))

endmodule

bind sync_length_frame_deframer slfd_checker u_slfd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.empty        (empty),
	.pop          (pop),
	.result_kind  (result_kind),
	.payload_byte (payload_byte),
	.service_id   (service_id),
	.frame_length (frame_length),
	.frame_done   (frame_done)
);
